@@ rtl/core/psf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_pkg
// Shared constants and types of the polygon scanline span fill block.
// ----------------------------------------------------------------------------
package psf_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 12;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAX_RESULTS      = 16;
    localparam int COLOR_BITS       = 24;
    localparam int CFG_IDX_BITS     = 2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_ROW    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_INNER = 2'd0,
        CFG_FENCE = 2'd1,
        CFG_COLOR = 2'd2,
        CFG_NONE  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_FIRST,
        ST_FETCH,
        ST_EDGE,
        ST_DIVGO,
        ST_DIV,
        ST_FIN,
        ST_INS,
        ST_EMIT,
        ST_EMB,
        ST_END,
        ST_OUT
    } state_t;

endpackage

@@ rtl/core/psf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module psf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/psf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psf_div #(
    parameter int NW = 42,
    parameter int DW = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quo,
    output logic          rem_nz,
    output logic          done
);
    localparam int CW = $clog2(NW + 1);

    logic [DW:0]   rem_reg, rem_next;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW+1:0] shifted, diff;

    // one shift-subtract step
    always_comb begin
        shifted = {rem_reg, quo_reg[NW-1]};
        diff    = shifted - {2'b00, den_reg};
        rem_next = diff[DW+1] ? shifted[DW:0] : diff[DW:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                den_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[NW-2:0], ~diff[DW+1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo    = quo_reg;
    assign rem_nz = |rem_reg;
    assign done   = done_reg;
endmodule

@@ rtl/core/polygon_scanline_span_fill.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_scanline_span_fill
// Even-odd scanline span generator over a stored polygon vertex list.
// ----------------------------------------------------------------------------
// Clear and append items are handled in the idle state. A row request walks
// the closed vertex list one edge at a time: fetch, then evaluate with the
// multiply, plus, for an edge that crosses the row, a divider start state, a
// serial divide, a state to form the intersection and an insertion sort with
// one shift per larger intersection already stored. Spans are then formed one
// per cycle in fence mode or in two states (EMIT, EMB) in fill mode, and each
// waits for its output transfer. All crossing edges share the single divider.
// The input is not ready while a row is in work.
module polygon_scanline_span_fill #(
    parameter int MAX_VERTICES = psf_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = psf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS    = psf_pkg::FRAC_BITS_DEF,
    parameter int IN_W  = ((2 + 3 * COORD_BITS + 7) / 8) * 8,
    parameter int OUT_W = ((3 * COORD_BITS + 28 + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // operation, vertex_x, vertex_y, row_y
    input  logic [IN_W-1:0]                s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // span_valid, span_row, span_start, span_end, span_xor, span_color
    output logic [OUT_W-1:0]               m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [psf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [psf_pkg::COLOR_BITS-1:0] cfg_data
);
    import psf_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int VI  = $clog2(MAX_VERTICES);
    localparam int VC  = $clog2(MAX_VERTICES + 1);
    localparam int PW  = 2 * C + 2;
    localparam int NW  = PW + F;
    localparam int XW  = C + F + 2;
    localparam int EW  = C + 3;
    localparam int RC  = $clog2(MAX_RESULTS + 1);
    localparam int SPW = 3 * C + 28;

    // configuration registers
    logic                  inner_reg, fence_reg;
    logic [COLOR_BITS-1:0] color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_reg <= 1'b0;
            fence_reg <= 1'b0;
            color_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_INNER: inner_reg <= cfg_data[0];
                CFG_FENCE: fence_reg <= cfg_data[0];
                CFG_COLOR: color_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // input fields
    op_t                  in_op;
    logic signed [C-1:0]  in_vx, in_vy, in_row;
    assign in_op  = op_t'(s_tdata[1:0]);
    assign in_vx  = s_tdata[2 +: C];
    assign in_vy  = s_tdata[2 + C +: C];
    assign in_row = s_tdata[2 + 2 * C +: C];

    state_t state_reg, state_next, ret_reg, ret_next;
    logic   s_acc;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // vertex store
    logic [VC-1:0]        total_reg, total_next;
    logic signed [C-1:0]  left_reg, left_next;
    logic                 ram_we;
    logic [VI-1:0]        ram_raddr;
    logic [2*C-1:0]       ram_rdata;
    logic signed [C-1:0]  rd_x, rd_y;

    psf_ram #(.WIDTH(2 * C), .DEPTH(MAX_VERTICES)) u_vram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (total_reg[VI-1:0]),
        .wdata ({in_vy, in_vx}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
    assign rd_x = ram_rdata[C-1:0];
    assign rd_y = ram_rdata[2*C-1:C];

    // row work registers
    logic signed [C-1:0]  row_reg, row_next;
    logic signed [C-1:0]  px_reg, px_next, py_reg, py_next;
    logic signed [C-1:0]  x1_reg, x1_next;
    logic [VC-1:0]        ei_reg, ei_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic                 dneg_reg, dneg_next;
    logic [C:0]           den_reg, den_next;
    logic [VC-1:0]        cnt_reg, cnt_next;
    logic [VC-1:0]        m_reg, m_next;
    logic signed [XW-1:0] v_reg, v_next;
    logic signed [XW-1:0] xs_reg [MAX_VERTICES];
    logic                 xs_we;
    logic [VI-1:0]        xs_waddr;
    logic signed [XW-1:0] xs_wdata;
    logic signed [EW-1:0] s_reg, s_next;
    logic [RC-1:0]        found_reg, found_next;
    logic                 pend_v_reg, pend_v_next;
    logic [SPW-1:0]       pend_reg, pend_next;
    logic [SPW-1:0]       out_reg, out_next;
    logic                 last_reg, last_next;

    // divider
    logic                 div_start, div_rnz, div_done;
    logic [NW-1:0]        div_quo;
    logic [PW-1:0]        prod_mag;
    logic                 qneg;

    assign prod_mag = prod_reg[PW-1] ? PW'(-prod_reg) : prod_reg;
    assign qneg     = (prod_reg != '0) && (prod_reg[PW-1] ^ dneg_reg);

    psf_div #(.NW(NW), .DW(C + 1)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({prod_mag, {F{1'b0}}}),
        .divisor  (den_reg),
        .quo      (div_quo),
        .rem_nz   (div_rnz),
        .done     (div_done)
    );

    // edge evaluation terms
    logic signed [C:0]    dy, dyr, dxe, fence;
    logic                 hit;
    logic [VC-1:0]        ei_inc;
    logic signed [NW:0]   q_floor;
    logic signed [XW-1:0] x_int;
    logic signed [XW-1:0] xs_rd;
    logic signed [EW-1:0] e_flr, e_ceil, s_adj, e_adj;
    logic                 emit_hit;
    logic [SPW-1:0]       span_new;
    logic [VC-1:0]        fetch_idx;

    always_comb begin
        dy     = (C + 1)'(rd_y) - (C + 1)'(py_reg);
        dyr    = (C + 1)'(row_reg) - (C + 1)'(py_reg);
        dxe    = (C + 1)'(rd_x) - (C + 1)'(px_reg);
        hit    = (rd_y != py_reg) &&
                 (row_reg >= ((rd_y < py_reg) ? rd_y : py_reg)) &&
                 (row_reg <  ((rd_y < py_reg) ? py_reg : rd_y));
        ei_inc = ei_reg + 1'b1;
        fetch_idx = (ei_inc == total_reg) ? '0 : ei_inc;
        q_floor = qneg ? ((NW + 1)'(-$signed({1'b0, div_quo})) - (NW + 1)'(div_rnz))
                       : $signed({1'b0, div_quo});
        x_int  = (XW'(x1_reg) <<< F) + XW'(q_floor);
        xs_rd  = xs_reg[ei_reg[VI-1:0]];
        e_flr  = EW'(xs_rd >>> F);
        e_ceil = EW'((XW + 1)'(xs_rd) + (XW + 1)'((1 << F) - 1) >>> F);
        fence  = (C + 1)'(left_reg) - 1'b1;
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        total_next  = total_reg;
        left_next   = left_reg;
        row_next    = row_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        x1_next     = x1_reg;
        ei_next     = ei_reg;
        prod_next   = prod_reg;
        dneg_next   = dneg_reg;
        den_next    = den_reg;
        cnt_next    = cnt_reg;
        m_next      = m_reg;
        v_next      = v_reg;
        s_next      = s_reg;
        found_next  = found_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        out_next    = out_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_raddr   = '0;
        div_start   = 1'b0;
        xs_we       = 1'b0;
        xs_waddr    = m_reg[VI-1:0];
        xs_wdata    = v_reg;
        emit_hit    = 1'b0;
        s_adj       = s_reg;
        e_adj       = e_flr;
        span_new    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (in_op)
                        OP_CLEAR: begin
                            total_next = '0;
                            left_next  = '0;
                        end
                        OP_APPEND: begin
                            if (total_reg < VC'(MAX_VERTICES)) begin
                                ram_we     = 1'b1;
                                total_next = total_reg + 1'b1;
                                if (total_reg == '0 || in_vx < left_reg) begin
                                    left_next = in_vx;
                                end
                            end
                        end
                        OP_ROW: begin
                            row_next    = in_row;
                            cnt_next    = '0;
                            ei_next     = '0;
                            found_next  = '0;
                            pend_v_next = 1'b0;
                            state_next  = (total_reg >= VC'(3)) ? ST_START : ST_END;
                        end
                        default: ;
                    endcase
                end
            end
            ST_START: begin
                ram_raddr  = '0;
                state_next = ST_FIRST;
            end
            ST_FIRST: begin
                px_next    = rd_x;
                py_next    = rd_y;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                ram_raddr  = fetch_idx[VI-1:0];
                state_next = ST_EDGE;
            end
            ST_EDGE: begin
                px_next   = rd_x;
                py_next   = rd_y;
                x1_next   = px_reg;
                prod_next = PW'(dyr * dxe);
                dneg_next = dy[C];
                den_next  = dy[C] ? -dy : dy;
                if (hit) begin
                    state_next = ST_DIVGO;
                end else begin
                    ei_next    = ei_inc;
                    state_next = (ei_inc == total_reg) ? ST_EMIT : ST_FETCH;
                    if (ei_inc == total_reg) ei_next = '0;
                end
            end
            ST_DIVGO: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_FIN;
            end
            ST_FIN: begin
                v_next     = x_int;
                m_next     = cnt_reg;
                state_next = ST_INS;
            end
            ST_INS: begin
                // insertion sort: one shift per cycle
                if (m_reg != '0 && xs_reg[VI'(m_reg - 1'b1)] > v_reg) begin
                    xs_we    = 1'b1;
                    xs_wdata = xs_reg[VI'(m_reg - 1'b1)];
                    m_next   = m_reg - 1'b1;
                end else begin
                    xs_we      = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    ei_next    = ei_inc;
                    state_next = (ei_inc == total_reg) ? ST_EMIT : ST_FETCH;
                    if (ei_inc == total_reg) ei_next = '0;
                end
            end
            ST_EMIT: begin
                if (found_reg == RC'(MAX_RESULTS) ||
                    (fence_reg ? (ei_reg >= cnt_reg) : (ei_inc >= cnt_reg))) begin
                    state_next = ST_END;
                end else if (fence_reg) begin
                    ei_next = ei_inc;
                    if (e_flr >= EW'(fence)) begin
                        emit_hit = 1'b1;
                        span_new = {~color_reg, 1'b1, (C + 1)'(e_flr), (C + 1)'(fence),
                                    row_reg, 1'b1};
                    end
                end else begin
                    s_next     = e_ceil;
                    ei_next    = ei_inc;
                    state_next = ST_EMB;
                end
            end
            ST_EMB: begin
                s_adj      = inner_reg ? s_reg + 1'b1 : s_reg;
                e_adj      = inner_reg ? e_flr - 1'b1 : e_flr;
                ei_next    = ei_inc;
                state_next = ST_EMIT;
                if (s_adj <= e_adj) begin
                    emit_hit = 1'b1;
                    span_new = {color_reg, 1'b0, (C + 1)'(e_adj), (C + 1)'(s_adj),
                                row_reg, 1'b1};
                end
            end
            ST_END: begin
                out_next   = pend_v_reg ? pend_reg : {{(SPW - C - 1){1'b0}}, row_reg, 1'b0};
                last_next  = 1'b1;
                ret_next   = ST_IDLE;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) state_next = ret_reg;
            end
            default: state_next = ST_IDLE;
        endcase

        // a new span pushes the held one out; the newest is held back for last
        if (emit_hit) begin
            found_next  = found_reg + 1'b1;
            pend_next   = span_new;
            pend_v_next = 1'b1;
            if (pend_v_reg) begin
                out_next   = pend_reg;
                last_next  = 1'b0;
                ret_next   = ST_EMIT;
                state_next = ST_OUT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            total_reg  <= '0;
            left_reg   <= '0;
            pend_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            total_reg  <= total_next;
            left_reg   <= left_next;
            pend_v_reg <= pend_v_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        row_reg   <= row_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        x1_reg    <= x1_next;
        ei_reg    <= ei_next;
        prod_reg  <= prod_next;
        dneg_reg  <= dneg_next;
        den_reg   <= den_next;
        cnt_reg   <= cnt_next;
        m_reg     <= m_next;
        v_reg     <= v_next;
        s_reg     <= s_next;
        found_reg <= found_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
        last_reg  <= last_next;
        if (xs_we) begin
            xs_reg[xs_waddr] <= xs_wdata;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = OUT_W'(out_reg);
    assign m_tlast  = last_reg;
endmodule
